// ----- sv/rmq_pkg.sv -----
package rmq_pkg;

    localparam int RAD_W     = 17;   // radicand, Q.14 units, always positive when used
    localparam int SQ_W      = 47;   // sqrt working width (radicand << 28 plus headroom)
    localparam int SQ_STEPS  = 23;   // one root bit per stage
    localparam int ROOT_W    = 23;   // root R in Q.21
    localparam int NUM_W     = 18;   // signed off-diagonal sum or difference
    localparam int DIVN_W    = 39;   // |n| << 21 plus R
    localparam int DVS_W     = 24;   // divisor 2R
    localparam int QUO_W     = 24;   // quotient bits
    localparam int DIV_STEPS = 24;   // one quotient bit per stage
    localparam int LANES     = 3;

    typedef logic [1:0] t_path;
    localparam t_path PATH_TRACE = 2'd0;
    localparam t_path PATH_X     = 2'd1;
    localparam t_path PATH_Y     = 2'd2;
    localparam t_path PATH_Z     = 2'd3;

    typedef logic signed [NUM_W-1:0] t_num;

    // travels alongside the sqrt pipeline
    typedef struct packed {
        logic  valid;
        t_path path;
        logic  degen;
        t_num  n_a;
        t_num  n_b;
        t_num  n_c;
    } t_sq_side;

    // travels alongside the divider lanes
    typedef struct packed {
        logic             valid;
        t_path            path;
        logic             degen;
        logic [LANES-1:0] neg;
        logic [15:0]      diag;
    } t_dv_side;

endpackage

// ----- sv/rmq_isqrt.sv -----
module rmq_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [rmq_pkg::RAD_W-1:0]  i_rad,
    input  rmq_pkg::t_sq_side          i_side,
    output logic [rmq_pkg::ROOT_W-1:0] o_root,
    output rmq_pkg::t_sq_side          o_side
);
    import rmq_pkg::*;

    logic [SQ_W-1:0] w_v   [0:SQ_STEPS];
    logic [SQ_W-1:0] w_res [0:SQ_STEPS];
    t_sq_side        w_side[0:SQ_STEPS];

    logic [SQ_W-1:0] r_v   [0:SQ_STEPS-1];
    logic [SQ_W-1:0] r_res [0:SQ_STEPS-1];
    t_sq_side        r_side[0:SQ_STEPS-1];

    assign w_v[0]    = SQ_W'(i_rad) << 28;
    assign w_res[0]  = '0;
    assign w_side[0] = i_side;

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_stage
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
            logic [SQ_W-1:0] trial;
            logic [SQ_W-1:0] n_v;
            logic [SQ_W-1:0] n_res;

            always_comb begin
                trial = w_res[k] + BIT;
                if (w_v[k] >= trial) begin
                    n_v   = w_v[k] - trial;
                    n_res = (w_res[k] >> 1) + BIT;
                end else begin
                    n_v   = w_v[k];
                    n_res = w_res[k] >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[k].valid <= 1'b0;
                end else if (i_en) begin
                    r_side[k].valid <= w_side[k].valid;
                end
                if (i_en) begin
                    r_v[k]          <= n_v;
                    r_res[k]        <= n_res;
                    r_side[k].path  <= w_side[k].path;
                    r_side[k].degen <= w_side[k].degen;
                    r_side[k].n_a   <= w_side[k].n_a;
                    r_side[k].n_b   <= w_side[k].n_b;
                    r_side[k].n_c   <= w_side[k].n_c;
                end
            end

            assign w_v[k+1]    = r_v[k];
            assign w_res[k+1]  = r_res[k];
            assign w_side[k+1] = r_side[k];
        end
    endgenerate

    assign o_root = w_res[SQ_STEPS][ROOT_W-1:0];
    assign o_side = w_side[SQ_STEPS];

endmodule

// ----- sv/rmq_div.sv -----
module rmq_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [rmq_pkg::DIVN_W-1:0] i_num,
    input  logic [rmq_pkg::DVS_W-1:0]  i_dvs,
    output logic [rmq_pkg::QUO_W-1:0]  o_quo
);
    import rmq_pkg::*;

    localparam int CMP_W = DVS_W + DIV_STEPS;

    logic [DIVN_W-1:0] w_rem[0:DIV_STEPS];
    logic [DVS_W-1:0]  w_dvs[0:DIV_STEPS];
    logic [QUO_W-1:0]  w_quo[0:DIV_STEPS];

    logic [DIVN_W-1:0] r_rem[0:DIV_STEPS-1];
    logic [DVS_W-1:0]  r_dvs[0:DIV_STEPS-1];
    logic [QUO_W-1:0]  r_quo[0:DIV_STEPS-1];

    assign w_rem[0] = i_num;
    assign w_dvs[0] = i_dvs;
    assign w_quo[0] = '0;

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_stage
            localparam int SH = DIV_STEPS - 1 - k;
            logic [CMP_W-1:0]  sub;
            logic [DIVN_W-1:0] n_rem;
            logic [QUO_W-1:0]  n_quo;

            always_comb begin
                sub   = CMP_W'(w_dvs[k]) << SH;
                n_rem = w_rem[k];
                n_quo = w_quo[k];
                if (CMP_W'(w_rem[k]) >= sub) begin
                    n_rem     = DIVN_W'(CMP_W'(w_rem[k]) - sub);
                    n_quo[SH] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_dvs[k] <= w_dvs[k];
                    r_quo[k] <= n_quo;
                end
            end

            assign w_rem[k+1] = r_rem[k];
            assign w_dvs[k+1] = r_dvs[k];
            assign w_quo[k+1] = r_quo[k];
        end
    endgenerate

    assign o_quo = w_quo[DIV_STEPS];

endmodule

// ----- sv/rotation_matrix_to_quaternion.sv -----
// channel  | valid    | ready    | beat
// ---------+----------+----------+-------------------------------------------
// input    | i_valid  | o_ready  | i_r0c0 .. i_r2c2
// output   | o_valid  | i_ready  | o_quat_w/x/y/z, o_path_taken, o_saturated,
//          |          |          | o_degenerate
//
// One beat per cycle unless a held output stalls; stages: front end, square
// root (one root bit per stage), divider prep, three divider lanes (one
// quotient bit per stage), output. Reset clears all valid bits. A held output
// stalls every stage together; o_ready is high unless the output holds a beat
// that i_ready refuses.
module rotation_matrix_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_r0c0,
    input  logic signed [15:0] i_r0c1,
    input  logic signed [15:0] i_r0c2,
    input  logic signed [15:0] i_r1c0,
    input  logic signed [15:0] i_r1c1,
    input  logic signed [15:0] i_r1c2,
    input  logic signed [15:0] i_r2c0,
    input  logic signed [15:0] i_r2c1,
    input  logic signed [15:0] i_r2c2,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z,
    output logic [1:0]         o_path_taken,
    output logic               o_saturated,
    output logic               o_degenerate
);
    import rmq_pkg::*;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---------------- front end: path choice, radicand, numerators
    logic signed [18:0] m00, m11, m22, d_tr, d_x, d_y, d_z, d_sel;
    t_num       s_21m12, s_02m20, s_10m01, s_10p01, s_02p20, s_21p12;
    t_path      f_path;
    t_sq_side   f_side;
    logic [RAD_W-1:0] f_rad;

    always_comb begin
        m00  = 19'(i_r0c0);
        m11  = 19'(i_r1c1);
        m22  = 19'(i_r2c2);
        d_tr = m00 + m11 + m22 + 19'sd16384;
        d_x  = 19'sd16384 + m00 - m11 - m22;
        d_y  = 19'sd16384 + m11 - m00 - m22;
        d_z  = 19'sd16384 + m22 - m00 - m11;
        s_21m12 = t_num'(i_r2c1) - t_num'(i_r1c2);
        s_02m20 = t_num'(i_r0c2) - t_num'(i_r2c0);
        s_10m01 = t_num'(i_r1c0) - t_num'(i_r0c1);
        s_10p01 = t_num'(i_r1c0) + t_num'(i_r0c1);
        s_02p20 = t_num'(i_r0c2) + t_num'(i_r2c0);
        s_21p12 = t_num'(i_r2c1) + t_num'(i_r1c2);

        if (d_tr > 0) begin
            f_path = PATH_TRACE;
            d_sel  = d_tr;
        end else if (i_r0c0 > i_r1c1 && i_r0c0 > i_r2c2) begin
            f_path = PATH_X;
            d_sel  = d_x;
        end else if (i_r1c1 > i_r2c2) begin
            f_path = PATH_Y;
            d_sel  = d_y;
        end else begin
            f_path = PATH_Z;
            d_sel  = d_z;
        end

        f_side.valid = i_valid;
        f_side.path  = f_path;
        f_side.degen = (d_sel <= 0);
        f_rad        = f_side.degen ? '0 : d_sel[RAD_W-1:0];

        // the three components other than the diagonal one, in w,x,y,z order
        case (f_path)
            PATH_TRACE: begin
                f_side.n_a = s_21m12; f_side.n_b = s_02m20; f_side.n_c = s_10m01;
            end
            PATH_X: begin
                f_side.n_a = s_21m12; f_side.n_b = s_10p01; f_side.n_c = s_02p20;
            end
            PATH_Y: begin
                f_side.n_a = s_02m20; f_side.n_b = s_10p01; f_side.n_c = s_21p12;
            end
            default: begin
                f_side.n_a = s_10m01; f_side.n_b = s_02p20; f_side.n_c = s_21p12;
            end
        endcase
    end

    t_sq_side         r_f_side;
    logic [RAD_W-1:0] r_f_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_side.valid <= 1'b0;
        end else if (en) begin
            r_f_side.valid <= f_side.valid;
        end
        if (en) begin
            r_f_side.path  <= f_side.path;
            r_f_side.degen <= f_side.degen;
            r_f_side.n_a   <= f_side.n_a;
            r_f_side.n_b   <= f_side.n_b;
            r_f_side.n_c   <= f_side.n_c;
            r_f_rad        <= f_rad;
        end
    end

    // ---------------- square root
    logic [ROOT_W-1:0] sq_root;
    t_sq_side          sq_side;

    rmq_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rad   (r_f_rad),
        .i_side  (r_f_side),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------- divider prep
    t_num              p_n[0:LANES-1];
    logic [NUM_W-2:0]  p_mag[0:LANES-1];
    logic [DIVN_W-1:0] n_p_num[0:LANES-1];
    logic [ROOT_W:0]   p_diag_sum;

    logic [DIVN_W-1:0] r_p_num[0:LANES-1];
    logic [DVS_W-1:0]  r_p_dvs;
    t_dv_side          r_p_side;

    assign p_n[0]     = sq_side.n_a;
    assign p_n[1]     = sq_side.n_b;
    assign p_n[2]     = sq_side.n_c;
    assign p_diag_sum = {1'b0, sq_root} + (ROOT_W + 1)'(128);

    genvar li;
    generate
        for (li = 0; li < LANES; li++) begin : g_prep
            assign p_mag[li]   = p_n[li][NUM_W-1] ? (NUM_W-1)'(-p_n[li])
                                                  : p_n[li][NUM_W-2:0];
            assign n_p_num[li] = DIVN_W'({p_mag[li], 21'b0}) + DIVN_W'(sq_root);

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_p_num[li] <= n_p_num[li];
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_side.valid <= 1'b0;
        end else if (en) begin
            r_p_side.valid <= sq_side.valid;
        end
        if (en) begin
            r_p_dvs        <= {sq_root, 1'b0};
            r_p_side.path  <= sq_side.path;
            r_p_side.degen <= sq_side.degen;
            r_p_side.neg   <= {p_n[2][NUM_W-1], p_n[1][NUM_W-1], p_n[0][NUM_W-1]};
            r_p_side.diag  <= p_diag_sum[23:8];
        end
    end

    // ---------------- divider lanes
    logic [QUO_W-1:0] dv_quo[0:LANES-1];

    generate
        for (li = 0; li < LANES; li++) begin : g_div
            rmq_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r_p_num[li]),
                .i_dvs (r_p_dvs),
                .o_quo (dv_quo[li])
            );
        end
    endgenerate

    t_dv_side r_d_side[0:DIV_STEPS-1];

    genvar di;
    generate
        for (di = 0; di < DIV_STEPS; di++) begin : g_dside
            t_dv_side prev;
            if (di == 0) begin : g_first
                assign prev = r_p_side;
            end else begin : g_rest
                assign prev = r_d_side[di-1];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d_side[di].valid <= 1'b0;
                end else if (en) begin
                    r_d_side[di].valid <= prev.valid;
                end
                if (en) begin
                    r_d_side[di].path  <= prev.path;
                    r_d_side[di].degen <= prev.degen;
                    r_d_side[di].neg   <= prev.neg;
                    r_d_side[di].diag  <= prev.diag;
                end
            end
        end
    endgenerate

    // ---------------- sign, saturate, place components
    t_dv_side             e_side;
    logic signed [15:0]   e_q[0:LANES-1];
    logic [LANES-1:0]     e_clip;
    logic signed [15:0]   n_w, n_x, n_y, n_z;
    logic                 n_sat;

    assign e_side = r_d_side[DIV_STEPS-1];

    generate
        for (li = 0; li < LANES; li++) begin : g_sat
            always_comb begin
                e_clip[li] = 1'b0;
                if (e_side.neg[li]) begin
                    if (dv_quo[li] > QUO_W'(32768)) begin
                        e_clip[li] = 1'b1;
                        e_q[li]    = -16'sd32768;
                    end else begin
                        e_q[li] = 16'(-dv_quo[li]);
                    end
                end else begin
                    if (dv_quo[li] > QUO_W'(32767)) begin
                        e_clip[li] = 1'b1;
                        e_q[li]    = 16'sd32767;
                    end else begin
                        e_q[li] = 16'(dv_quo[li]);
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        // diagonal term stays below 2^15, no clip possible
        case (e_side.path)
            PATH_TRACE: begin
                n_w = e_side.diag; n_x = e_q[0]; n_y = e_q[1]; n_z = e_q[2];
            end
            PATH_X: begin
                n_w = e_q[0]; n_x = e_side.diag; n_y = e_q[1]; n_z = e_q[2];
            end
            PATH_Y: begin
                n_w = e_q[0]; n_x = e_q[1]; n_y = e_side.diag; n_z = e_q[2];
            end
            default: begin
                n_w = e_q[0]; n_x = e_q[1]; n_y = e_q[2]; n_z = e_side.diag;
            end
        endcase
        n_sat = |e_clip;
        if (e_side.degen) begin
            n_w   = '0;
            n_x   = '0;
            n_y   = '0;
            n_z   = '0;
            n_sat = 1'b0;
        end
    end

    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= e_side.valid;
        end
        if (en) begin
            o_quat_w     <= n_w;
            o_quat_x     <= n_x;
            o_quat_y     <= n_y;
            o_quat_z     <= n_z;
            o_path_taken <= e_side.path;
            o_saturated  <= n_sat;
            o_degenerate <= e_side.degen;
        end
    end

    assign o_valid = r_o_valid;

    // ---------------- checks
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_quat_w == 0 && o_quat_x == 0 &&
                                    o_quat_y == 0 && o_quat_z == 0 && !o_saturated)
        else $error("degenerate result not cleared");

    a_trace_never_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_path_taken == PATH_TRACE |-> !o_degenerate)
        else $error("trace path flagged degenerate");

    a_trace_w_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_path_taken == PATH_TRACE |-> o_quat_w > 0)
        else $error("trace path gave non-positive w");

endmodule
